/* hdl/gbsf_pkg.sv */
`default_nettype none

package gbsf_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned HELD_W  = 24;
    localparam int unsigned CODE_W  = 32;
    localparam int unsigned COUNT_W = 3;
    localparam int unsigned PHASE_W = 2;

    // Output stream payload widths: code and byte count in tdata, padded to bytes.
    localparam int unsigned M_TDATA_W = 40;
    localparam int unsigned M_TUSER_W = 3;

    localparam logic [BYTE_W-1:0] HIGH_MIN = 8'hA1;
    localparam logic [BYTE_W-1:0] PASS_MAX = 8'h80;
    localparam logic [BYTE_W-1:0] BAD_BYTE = 8'hFF;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOS  = 1'b1;

    typedef enum logic [1:0] {
        SEQ_SINGLE  = 2'd0,
        SEQ_TWO     = 2'd1,
        SEQ_FOUR    = 2'd2,
        SEQ_INVALID = 2'd3
    } t_seq_class;

    typedef struct packed {
        logic                valid;
        t_seq_class          seq_class;
        logic [CODE_W-1:0]   code;
        logic [COUNT_W-1:0]  byte_count;
        logic                high_pair;
    } t_result;

endpackage

`default_nettype wire

/* hdl/gbsf_step.sv */
`default_nettype none

module gbsf_step (
    input  wire logic [gbsf_pkg::PHASE_W-1:0] i_phase,
    input  wire logic [gbsf_pkg::HELD_W-1:0]  i_held,
    input  wire logic                         i_kind,
    input  wire logic [gbsf_pkg::BYTE_W-1:0]  i_byte,
    output logic      [gbsf_pkg::PHASE_W-1:0] o_phase,
    output logic      [gbsf_pkg::HELD_W-1:0]  o_held,
    output gbsf_pkg::t_result                 o_result
);
    import gbsf_pkg::*;

    logic [CODE_W-1:0] w_joined;
    logic              w_lead;
    logic              w_digit;
    logic              w_trail;

    assign w_joined = {i_held, i_byte};
    assign w_lead   = (i_byte inside {[8'h81:8'hFE]});
    assign w_digit  = (i_byte inside {[8'h30:8'h39]});
    assign w_trail  = (i_byte inside {[8'h40:8'h7E]}) || (i_byte inside {[PASS_MAX:8'hFE]});

    always_comb begin
        // Any emitted result clears the pending bytes.
        o_phase             = '0;
        o_held              = '0;
        o_result.valid      = 1'b1;
        o_result.seq_class  = SEQ_INVALID;
        o_result.code       = w_joined;
        o_result.byte_count = COUNT_W'(i_phase) + COUNT_W'(1);
        o_result.high_pair  = 1'b0;

        if (i_kind == KIND_EOS) begin
            o_result.valid      = (i_phase != '0);
            o_result.code       = {{(CODE_W-HELD_W){1'b0}}, i_held};
            o_result.byte_count = COUNT_W'(i_phase);
        end else begin
            case (i_phase)
                2'd0: begin
                    if (w_lead) begin
                        o_result.valid = 1'b0;
                        o_phase        = 2'd1;
                        o_held         = HELD_W'(i_byte);
                    end else if (i_byte != BAD_BYTE) begin
                        o_result.seq_class = SEQ_SINGLE;
                    end
                end
                2'd1: begin
                    if (w_trail) begin
                        o_result.seq_class = SEQ_TWO;
                        o_result.high_pair = (i_held[BYTE_W-1:0] >= HIGH_MIN) &&
                                             (i_byte >= HIGH_MIN);
                    end else if (w_digit) begin
                        o_result.valid = 1'b0;
                        o_phase        = 2'd2;
                        o_held         = w_joined[HELD_W-1:0];
                    end
                end
                2'd2: begin
                    if (w_lead) begin
                        o_result.valid = 1'b0;
                        o_phase        = 2'd3;
                        o_held         = w_joined[HELD_W-1:0];
                    end
                end
                default: begin
                    if (w_digit) begin
                        o_result.seq_class = SEQ_FOUR;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* hdl/gb18030_sequence_framer.sv */
// A byte accepted into the input register reaches the output through the result register.
// Throughput: one byte per cycle while the output is not stalled; the state update is a single pass of range compares
// between the input register and the result register.
// Output stalls hold the result register, and the input side keeps accepting until
// the input register is also full.
// Reset (synchronous, active low) empties both registers and clears any pending bytes.
`default_nettype none

module gb18030_sequence_framer (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  wire logic [gbsf_pkg::BYTE_W-1:0]      i_s_axis_tdata,  // [7:0] data_byte
    input  wire logic                             i_s_axis_tuser,  // [0] kind
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    output logic      [gbsf_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,  // [31:0] code, [34:32] byte_count
    output logic      [gbsf_pkg::M_TUSER_W-1:0]   o_m_axis_tuser   // [1:0] sequence_class, [2] high_pair
);
    import gbsf_pkg::*;

    logic                r_in_valid;
    logic                r_in_kind;
    logic [BYTE_W-1:0]   r_in_byte;
    logic [PHASE_W-1:0]  r_phase;
    logic [HELD_W-1:0]   r_held;
    logic                r_out_valid;
    t_result             r_out;

    logic [PHASE_W-1:0]  n_phase;
    logic [HELD_W-1:0]   n_held;
    t_result             n_result;

    logic                w_out_free;
    logic                w_in_ready;
    logic                w_advance;

    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_in_ready = !r_in_valid || w_out_free;
    assign w_advance  = r_in_valid && w_out_free;

    gbsf_step u_step (
        .i_phase  (r_phase),
        .i_held   (r_held),
        .i_kind   (r_in_kind),
        .i_byte   (r_in_byte),
        .o_phase  (n_phase),
        .o_held   (n_held),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= '0;
            r_held      <= '0;
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_advance) begin
                r_phase <= n_phase;
                r_held  <= n_held;
            end
            if (w_out_free) begin
                r_out_valid <= w_advance && n_result.valid;
            end
        end
        if (w_in_ready && i_s_axis_tvalid) begin
            r_in_kind <= i_s_axis_tuser;
            r_in_byte <= i_s_axis_tdata;
        end
        if (w_advance && n_result.valid) begin
            r_out <= n_result;
        end
    end

    assign o_s_axis_tready = w_in_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(M_TDATA_W-CODE_W-COUNT_W){1'b0}}, r_out.byte_count, r_out.code};
    assign o_m_axis_tuser  = {r_out.high_pair, r_out.seq_class};

endmodule

`default_nettype wire

/* hdl/gbsf_checker.sv */
`default_nettype none

module gbsf_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           o_m_axis_tvalid,
    input wire logic                           i_m_axis_tready,
    input wire logic [gbsf_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    input wire logic [gbsf_pkg::M_TUSER_W-1:0] o_m_axis_tuser
);
    import gbsf_pkg::*;

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[34:32] != 3'd0 && o_m_axis_tdata[34:32] <= 3'd4)
        else $error("byte count out of range");

    a_high_pair_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[2] |-> o_m_axis_tuser[1:0] == SEQ_TWO)
        else $error("high pair flag on a sequence that is not a two-byte code");

    a_single_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1:0] == SEQ_SINGLE |->
            o_m_axis_tdata[34:32] == 3'd1 && o_m_axis_tdata[31:8] == 24'd0 &&
            o_m_axis_tdata[7:0] <= PASS_MAX)
        else $error("malformed single-byte result");

    a_four_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1:0] == SEQ_FOUR |-> o_m_axis_tdata[34:32] == 3'd4)
        else $error("four-byte code with wrong byte count");

endmodule

bind gb18030_sequence_framer gbsf_checker u_gbsf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire
